FILE: sv/fba_pkg.sv
// fba_pkg: shared types, constants and helper function of the frame bitmap allocator
// no dependencies; imported by fba_apb_regs and frame_bitmap_allocator_unit
package fba_pkg;

    // bitmap geometry
    localparam int MAX_FRAMES = 32768;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = MAX_FRAMES / WORD_BITS;
    localparam int NUM_GROUPS = NUM_WORDS / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_AW    = $clog2(NUM_WORDS);
    localparam int GRP_W      = $clog2(NUM_GROUPS);
    localparam int FRAME_W    = 15;
    localparam int COUNT_W    = 16;

    // configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT = '0;
    localparam logic [COUNT_W-1:0]   FRAME_COUNT_RESET = 16'h1000;

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_MAPPED   = 2'd1;
    localparam logic [1:0] STAT_NO_FRAME = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WORD,
        ST_BIT,
        ST_FREE_WR,
        ST_RESP
    } fba_state_t;

    // lowest clear bit of a word
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } fz_t;

    function automatic fz_t first_zero(input logic [WORD_BITS-1:0] v);
        fz_t r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                r.found = 1'b1;
                r.idx   = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: sv/frame_bitmap_allocator_unit.sv
// Frame bitmap allocator: one bit per physical page frame, 1024 words of 32 bits in a
// synchronous RAM, plus a 32x32 RAM of full-word flags and 32 full-group flip-flops.
// Allocate does a first-fit search through the two summary levels. The accept cycle reads
// the word flags of the lowest group with room. The next cycle (ST_WORD) reads the bitmap
// word. ST_BIT then picks the bit, writes the word back and registers the result, once the
// result register is free. The next request can be accepted in the cycle that the result
// turns valid. A free reads the word and its flag word on the accept cycle and writes both
// back in ST_FREE_WR, once the result register is free. Requests with nothing to change
// go through ST_RESP. A result still waiting for out_ready stalls the sequencer in its last
// state.
// One request is in flight at a time; the RAM read-modify-write loop sets the pace.
// After reset the block clears the bitmap RAM one word per cycle and holds in_ready low
// until done; configuration writes are taken during that time.
// Depends on fba_pkg and fba_apb_regs.
module frame_bitmap_allocator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [fba_pkg::FRAME_W-1:0]   page_frame,
    input  logic                          kernel_page,
    input  logic                          write_access,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fba_pkg::FRAME_W-1:0]   frame_number,
    output logic                          present,
    output logic                          writable,
    output logic                          user_mode,
    output logic [1:0]                    status,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fba_pkg::PADDR_W-1:0]   paddr,
    input  logic [fba_pkg::PDATA_W-1:0]   pwdata,
    output logic [fba_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import fba_pkg::*;

    // configuration
    logic [COUNT_W-1:0] frame_count;

    fba_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .frame_count (frame_count)
    );

    // memories
    logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] summary_mem [NUM_GROUPS];

    // control state
    fba_state_t            state_reg, state_next;
    logic [WORD_AW-1:0]    clr_cnt_reg;
    logic [NUM_GROUPS-1:0] group_full_reg;
    logic                  out_valid_reg;

    // request and search registers
    logic                  op_reg;
    logic [FRAME_W-1:0]    pf_reg;
    logic                  kern_reg;
    logic                  wr_reg;
    logic [1:0]            stat_reg;
    logic [GRP_W-1:0]      grp_reg;
    logic [BIT_W-1:0]      w_reg;
    logic [WORD_BITS-1:0]  bm_rdata_reg;
    logic [WORD_BITS-1:0]  sum_rdata_reg;

    // result registers
    logic [FRAME_W-1:0]    frame_number_reg;
    logic                  present_reg;
    logic                  writable_reg;
    logic                  user_mode_reg;
    logic [1:0]            status_reg;

    // datapath
    fz_t                   grp_find;
    fz_t                   w_find;
    fz_t                   b_find;
    logic [FRAME_W-1:0]    cand_frame;
    logic                  alloc_ok;
    logic [WORD_BITS-1:0]  bm_set_word;
    logic [WORD_BITS-1:0]  sum_set_word;
    logic [WORD_BITS-1:0]  bm_clr_word;
    logic [WORD_BITS-1:0]  sum_clr_word;
    logic                  go;
    logic                  accept;

    // memory and control strobes
    logic                  bm_re;
    logic [WORD_AW-1:0]    bm_raddr;
    logic                  bm_we;
    logic [WORD_AW-1:0]    bm_waddr;
    logic [WORD_BITS-1:0]  bm_wdata;
    logic                  sum_re;
    logic [GRP_W-1:0]      sum_raddr;
    logic                  sum_we;
    logic [GRP_W-1:0]      sum_waddr;
    logic [WORD_BITS-1:0]  sum_wdata;
    logic                  grp_set;
    logic                  grp_clr;
    logic [GRP_W-1:0]      grp_idx;
    logic                  out_load;
    logic [FRAME_W-1:0]    o_frame;
    logic                  o_present;
    logic                  o_writable;
    logic                  o_user;
    logic [1:0]            o_status;

    // search and update datapath
    assign grp_find     = first_zero(group_full_reg);
    assign w_find       = first_zero(sum_rdata_reg);
    assign b_find       = first_zero(bm_rdata_reg);
    assign cand_frame   = {grp_reg, w_reg, b_find.idx};
    assign alloc_ok     = b_find.found && ({1'b0, cand_frame} < frame_count);
    assign bm_set_word  = bm_rdata_reg | (WORD_BITS'(1) << b_find.idx);
    assign sum_set_word = sum_rdata_reg | (WORD_BITS'(1) << w_reg);
    assign bm_clr_word  = bm_rdata_reg & ~(WORD_BITS'(1) << pf_reg[BIT_W-1:0]);
    assign sum_clr_word = sum_rdata_reg & ~(WORD_BITS'(1) << pf_reg[2*BIT_W-1:BIT_W]);
    assign go           = !out_valid_reg || out_ready;
    assign accept       = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_FREE && page_frame != '0)
                    begin
                        state_next = ST_FREE_WR;
                    end
                    else if (op == OP_ALLOC && page_frame == '0 && grp_find.found)
                    begin
                        state_next = ST_WORD;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_WORD:
            begin
                state_next = ST_BIT;
            end
            ST_BIT, ST_FREE_WR, ST_RESP:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        bm_re      = 1'b0;
        bm_raddr   = {grp_reg, w_find.idx};
        bm_we      = 1'b0;
        bm_waddr   = clr_cnt_reg;
        bm_wdata   = '0;
        sum_re     = 1'b0;
        sum_raddr  = grp_find.idx;
        sum_we     = 1'b0;
        sum_waddr  = clr_cnt_reg[GRP_W-1:0];
        sum_wdata  = '0;
        grp_set    = 1'b0;
        grp_clr    = 1'b0;
        grp_idx    = grp_reg;
        out_load   = 1'b0;
        o_frame    = '0;
        o_present  = 1'b0;
        o_writable = 1'b0;
        o_user     = 1'b0;
        o_status   = STAT_DONE;
        case (state_reg)
            ST_CLEAR:
            begin
                bm_we  = 1'b1;
                sum_we = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (op == OP_FREE && page_frame != '0)
                    begin
                        bm_re     = 1'b1;
                        bm_raddr  = page_frame[FRAME_W-1:BIT_W];
                        sum_re    = 1'b1;
                        sum_raddr = page_frame[FRAME_W-1:2*BIT_W];
                    end
                    else if (op == OP_ALLOC && page_frame == '0 && grp_find.found)
                    begin
                        sum_re = 1'b1;
                    end
                end
            end
            ST_WORD:
            begin
                bm_re = 1'b1;
            end
            ST_BIT:
            begin
                if (go)
                begin
                    out_load = 1'b1;
                    if (alloc_ok)
                    begin
                        bm_we      = 1'b1;
                        bm_waddr   = {grp_reg, w_reg};
                        bm_wdata   = bm_set_word;
                        o_frame    = cand_frame;
                        o_present  = 1'b1;
                        o_writable = wr_reg;
                        o_user     = !kern_reg;
                        if (&bm_set_word)
                        begin
                            sum_we    = 1'b1;
                            sum_waddr = grp_reg;
                            sum_wdata = sum_set_word;
                            grp_set   = &sum_set_word;
                        end
                    end
                    else
                    begin
                        o_status = STAT_FULL;
                    end
                end
            end
            ST_FREE_WR:
            begin
                if (go)
                begin
                    out_load  = 1'b1;
                    bm_we     = 1'b1;
                    bm_waddr  = pf_reg[FRAME_W-1:BIT_W];
                    bm_wdata  = bm_clr_word;
                    sum_we    = 1'b1;
                    sum_waddr = pf_reg[FRAME_W-1:2*BIT_W];
                    sum_wdata = sum_clr_word;
                    grp_clr   = 1'b1;
                    grp_idx   = pf_reg[FRAME_W-1:2*BIT_W];
                end
            end
            ST_RESP:
            begin
                if (go)
                begin
                    out_load = 1'b1;
                    o_status = stat_reg;
                    if (stat_reg == STAT_MAPPED)
                    begin
                        o_frame = pf_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // bitmap ram
    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bitmap_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re)
        begin
            bm_rdata_reg <= bitmap_mem[bm_raddr];
        end
    end

    // full-word summary ram
    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            summary_mem[sum_waddr] <= sum_wdata;
        end
        if (sum_re)
        begin
            sum_rdata_reg <= summary_mem[sum_raddr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            group_full_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (grp_set)
            begin
                group_full_reg[grp_idx] <= 1'b1;
            end
            else if (grp_clr)
            begin
                group_full_reg[grp_idx] <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture and search position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            pf_reg   <= page_frame;
            kern_reg <= kernel_page;
            wr_reg   <= write_access;
            grp_reg  <= grp_find.idx;
            if (op == OP_ALLOC && page_frame != '0)
            begin
                stat_reg <= STAT_MAPPED;
            end
            else if (op == OP_FREE)
            begin
                stat_reg <= STAT_NO_FRAME;
            end
            else
            begin
                stat_reg <= STAT_FULL;
            end
        end
        if (state_reg == ST_WORD)
        begin
            w_reg <= w_find.idx;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            frame_number_reg <= o_frame;
            present_reg      <= o_present;
            writable_reg     <= o_writable;
            user_mode_reg    <= o_user;
            status_reg       <= o_status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_number = frame_number_reg;
    assign present      = present_reg;
    assign writable     = writable_reg;
    assign user_mode    = user_mode_reg;
    assign status       = status_reg;

    // a fresh allocation always lies below the frame limit
    a_alloc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && o_present |-> {1'b0, o_frame} < frame_count)
        else $error("allocated frame at or above frame_count");

    // the allocated bit was free in the word read back
    a_alloc_bit_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BIT && bm_we |-> !bm_rdata_reg[b_find.idx])
        else $error("allocation hit a frame already in use");

    // only allocations travel the search path
    a_search_is_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WORD |-> op_reg == OP_ALLOC && pf_reg == '0)
        else $error("search started for a non-allocating transaction");

    // no full-group flag can appear before the bitmap is cleared
    a_clear_groups: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> group_full_reg == '0)
        else $error("group flag set during clearing pass");

    // an accepted request leaves idle on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE && !in_ready)
        else $error("request accepted but sequencer stayed idle");

endmodule

FILE: sv/fba_apb_regs.sv
// fba_apb_regs: APB configuration register file (frame_count)
// depends on fba_pkg
module fba_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fba_pkg::PADDR_W-1:0]   paddr,
    input  logic [fba_pkg::PDATA_W-1:0]   pwdata,
    output logic [fba_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [fba_pkg::COUNT_W-1:0]   frame_count
);
    import fba_pkg::*;

    logic [COUNT_W-1:0]   frame_count_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FRAME_COUNT_RESET;
        end
        else if (wr_en && reg_idx == REG_FRAME_COUNT)
        begin
            frame_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // register read
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_FRAME_COUNT)
        begin
            prdata = PDATA_W'(frame_count_reg);
        end
    end

    assign frame_count = frame_count_reg;

endmodule

FILE: tb/sv/frame_bitmap_allocator_unit_tb.sv
// testbench of frame_bitmap_allocator_unit: first-fit frame allocation and frame release
// depends on fba_pkg and the allocator rtl; self-checking against its own bitmap model
module frame_bitmap_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fba_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 205;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [PADDR_W-1:0] ADDR_FRAME_COUNT = {REG_FRAME_COUNT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNUSED      = {~REG_FRAME_COUNT, 2'b00};

    typedef struct packed {
        logic [FRAME_W-1:0] frame_number;
        logic               present;
        logic               writable;
        logic               user_mode;
        logic [1:0]         status;
    } alloc_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 req_op;
    logic [FRAME_W-1:0]   req_page_frame;
    logic                 req_kernel_page;
    logic                 req_write_access;
    logic                 out_valid;
    logic                 out_ready;
    logic [FRAME_W-1:0]   rsp_frame_number;
    logic                 rsp_present;
    logic                 rsp_writable;
    logic                 rsp_user_mode;
    logic [1:0]           rsp_status;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // model of the frame bitmap and the frame count register
    logic [WORD_BITS-1:0] frame_map [0:NUM_WORDS-1];
    logic [COUNT_W-1:0]   model_frame_count;

    alloc_result_t        pending_results[$];
    int                   held_frames[$];
    int                   error_count;
    bit                   idle_on;
    int                   rx_hold_len;
    int                   idle_cycles;

    frame_bitmap_allocator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (req_op),
        .page_frame   (req_page_frame),
        .kernel_page  (req_kernel_page),
        .write_access (req_write_access),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_number (rsp_frame_number),
        .present      (rsp_present),
        .writable     (rsp_writable),
        .user_mode    (rsp_user_mode),
        .status       (rsp_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // clock, 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // lowest free frame below the clamped count, -1 when none
    function automatic int lowest_free_frame();
        int                   lim;
        logic [WORD_BITS-1:0] word;
        lim = (int'(model_frame_count) > MAX_FRAMES) ? MAX_FRAMES : int'(model_frame_count);
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            if (w * WORD_BITS >= lim)
                return -1;
            word = frame_map[w];
            if (word != '1)
            begin
                for (int b = 0; b < WORD_BITS; b++)
                begin
                    if (w * WORD_BITS + b >= lim)
                        return -1;
                    if (!word[b])
                        return w * WORD_BITS + b;
                end
            end
        end
        return -1;
    endfunction

    // result of one request, updates the bitmap model
    function automatic alloc_result_t predict_request(logic opc, logic [FRAME_W-1:0] pf,
                                                      logic kern, logic wr);
        alloc_result_t        r;
        int                   f;
        logic [WORD_BITS-1:0] word;
        r = '0;
        if (opc == OP_ALLOC)
        begin
            if (pf != '0)
            begin
                r.frame_number = pf;
                r.status       = STAT_MAPPED;
            end
            else
            begin
                f = lowest_free_frame();
                if (f < 0)
                    r.status = STAT_FULL;
                else
                begin
                    word = frame_map[f / WORD_BITS];
                    word[f % WORD_BITS] = 1'b1;
                    frame_map[f / WORD_BITS] = word;
                    r.frame_number = FRAME_W'(f);
                    r.present      = 1'b1;
                    r.writable     = wr;
                    r.user_mode    = !kern;
                    r.status       = STAT_DONE;
                end
            end
        end
        else if (pf == '0)
            r.status = STAT_NO_FRAME;
        else
        begin
            f = int'(pf);
            word = frame_map[f / WORD_BITS];
            word[f % WORD_BITS] = 1'b0;
            frame_map[f / WORD_BITS] = word;
            r.status = STAT_DONE;
        end
        return r;
    endfunction

    // idle length, mostly short and a few long
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // send one request transaction and record its expected result
    task automatic send_req(logic opc, logic [FRAME_W-1:0] pf, logic kern, logic wr);
        alloc_result_t r;
        int            gap;
        in_valid         <= 1'b1;
        req_op           <= opc;
        req_page_frame   <= pf;
        req_kernel_page  <= kern;
        req_write_access <= wr;
        do
            @(posedge clk);
        while (!in_ready);
        r = predict_request(opc, pf, kern, wr);
        pending_results.push_back(r);
        if (opc == OP_ALLOC && r.present)
            held_frames.push_back(int'(r.frame_number));
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait until every result is back and the block has settled
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one apb transfer: setup cycle then access cycle
    task automatic apb_xfer(logic wr, logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data,
                            output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        if (wr && addr[PADDR_W-1:2] == REG_FRAME_COUNT)
            model_frame_count = data[COUNT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // write a register while idle, then read the count back
    task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] rdata;
        wait_idle();
        apb_xfer(1'b1, addr, data, rdata);
        apb_xfer(1'b0, ADDR_FRAME_COUNT, '0, rdata);
        if (rdata !== PDATA_W'(model_frame_count))
        begin
            $display("%0t frame_count readback: expected %0d actual %0d",
                     $time, model_frame_count, rdata);
            error_count++;
        end
    endtask

    // extremes of the fields and every special case
    task automatic test_directed();
        send_req(OP_ALLOC, '0, 1'b0, 1'b1);
        send_req(OP_ALLOC, '0, 1'b1, 1'b0);
        send_req(OP_ALLOC, '1, 1'b1, 1'b1);
        send_req(OP_FREE, '0, 1'b1, 1'b1);
        send_req(OP_FREE, 15'd1, 1'b0, 1'b0);
        send_req(OP_ALLOC, '0, 1'b0, 1'b0);
        send_req(OP_FREE, '1, 1'b0, 1'b1);
        send_req(OP_FREE, 15'd5000, 1'b1, 1'b0);
        // tiny map fills up
        write_reg(ADDR_FRAME_COUNT, 32'd2);
        send_req(OP_ALLOC, '0, 1'b0, 1'b1);
        send_req(OP_FREE, 15'd1, 1'b0, 1'b0);
        send_req(OP_ALLOC, '0, 1'b1, 1'b1);
        send_req(OP_ALLOC, '0, 1'b1, 1'b0);
        // unknown register index leaves the count alone
        write_reg(ADDR_UNUSED, 32'h0000_ffff);
        send_req(OP_ALLOC, '0, 1'b0, 1'b0);
        // empty map
        write_reg(ADDR_FRAME_COUNT, 32'd0);
        send_req(OP_ALLOC, '0, 1'b0, 1'b1);
        send_req(OP_FREE, 15'h4000, 1'b1, 1'b1);
        send_req(OP_ALLOC, 15'h4000, 1'b0, 1'b1);
        // count above the bitmap size is clamped
        write_reg(ADDR_FRAME_COUNT, 32'h0000_ffff);
        send_req(OP_ALLOC, '0, 1'b1, 1'b1);
        send_req(OP_ALLOC, '0, 1'b0, 1'b0);
        // whole bitmap
        write_reg(ADDR_FRAME_COUNT, MAX_FRAMES);
        send_req(OP_ALLOC, '0, 1'b0, 1'b1);
        send_req(OP_FREE, 15'd4, 1'b0, 1'b0);
        send_req(OP_ALLOC, '0, 1'b1, 1'b0);
    endtask

    // random mix of allocations and frees at one frame count
    task automatic random_phase(logic [COUNT_W-1:0] count, int n, bit steady);
        int                 r;
        int                 idx;
        logic [FRAME_W-1:0] pf;
        write_reg(ADDR_FRAME_COUNT, PDATA_W'(count));
        idle_on = !steady;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_req(OP_ALLOC, '0, 1'($urandom), 1'($urandom));
            else if (r < 55)
            begin
                pf = FRAME_W'($urandom_range(1, (1 << FRAME_W) - 1));
                send_req(OP_ALLOC, pf, 1'($urandom), 1'($urandom));
            end
            else if (r < 85 && held_frames.size() > 0)
            begin
                idx = $urandom_range(0, held_frames.size() - 1);
                pf  = FRAME_W'(held_frames[idx]);
                held_frames.delete(idx);
                send_req(OP_FREE, pf, 1'($urandom), 1'($urandom));
            end
            else if (r < 95)
                send_req(OP_FREE, FRAME_W'($urandom), 1'($urandom), 1'($urandom));
            else
                send_req(OP_FREE, '0, 1'($urandom), 1'($urandom));
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        random_phase(16'd48, PHASE_ITEMS, 1'b0);
        random_phase(16'd40, PHASE_ITEMS, 1'b0);
        random_phase(16'd0, PHASE_ITEMS / 4, 1'b0);
        random_phase(16'd1, PHASE_ITEMS, 1'b1);
        random_phase(16'd33, PHASE_ITEMS, 1'b0);
        random_phase(16'd32768, PHASE_ITEMS, 1'b0);
        random_phase(16'hffff, PHASE_ITEMS, 1'b1);
        random_phase(COUNT_W'($urandom_range(2, 300)), PHASE_ITEMS, 1'b0);
        random_phase(16'd4096, PHASE_ITEMS, 1'b0);
    endtask

    // receiver holds off while requests keep coming, then the sender drains
    task automatic test_backpressure();
        wait_idle();
        idle_on     = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        for (int i = 0; i < 12; i++)
            send_req(i[0] ? OP_FREE : OP_ALLOC, '0, 1'($urandom), 1'($urandom));
        in_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        idle_on = 1'b1;
        for (int i = 0; i < 12; i++)
            send_req(OP_ALLOC, '0, 1'($urandom), 1'($urandom));
    endtask

    // receiver: random ready with runs and gaps, or a long hold when asked
    initial
    begin : receiver
        int rx_run;
        int hold_n;
        int gap;
        rx_run = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_len > 0)
            begin
                hold_n      = rx_hold_len;
                rx_hold_len = 0;
                out_ready <= 1'b0;
                repeat (hold_n - 1) @(posedge clk);
                rx_run = 0;
            end
            else if (!idle_on)
                out_ready <= 1'b1;
            else if (rx_run > 0)
                rx_run--;
            else if (out_ready)
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    rx_run = gap - 1;
                end
            end
            else
            begin
                out_ready <= 1'b1;
                rx_run = $urandom_range(0, 7);
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : check_result
        alloc_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: frame_number %0d status %0d",
                         $time, rsp_frame_number, rsp_status);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (rsp_frame_number !== exp_r.frame_number)
                begin
                    $display("%0t frame_number: expected %0d actual %0d",
                             $time, exp_r.frame_number, rsp_frame_number);
                    error_count++;
                end
                if (rsp_present !== exp_r.present)
                begin
                    $display("%0t present: expected %0d actual %0d",
                             $time, exp_r.present, rsp_present);
                    error_count++;
                end
                if (rsp_writable !== exp_r.writable)
                begin
                    $display("%0t writable: expected %0d actual %0d",
                             $time, exp_r.writable, rsp_writable);
                    error_count++;
                end
                if (rsp_user_mode !== exp_r.user_mode)
                begin
                    $display("%0t user_mode: expected %0d actual %0d",
                             $time, exp_r.user_mode, rsp_user_mode);
                    error_count++;
                end
                if (rsp_status !== exp_r.status)
                begin
                    $display("%0t status: expected %0d actual %0d",
                             $time, exp_r.status, rsp_status);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any port
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // reset, test sequence and final verdict
    initial
    begin
        error_count      = 0;
        idle_on          = 1'b1;
        rx_hold_len      = 0;
        idle_cycles      = 0;
        model_frame_count = FRAME_COUNT_RESET;
        for (int w = 0; w < NUM_WORDS; w++)
            frame_map[w] = '0;
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        req_op           <= OP_ALLOC;
        req_page_frame   <= '0;
        req_kernel_page  <= 1'b0;
        req_write_access <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_backpressure();

        wait_idle();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
